@@ design/mono_page_framebuffer_engine_macros.svh @@
// Assertion macros shared by the framebuffer engine RTL.
`ifndef MONO_PAGE_FRAMEBUFFER_ENGINE_MACROS_SVH
`define MONO_PAGE_FRAMEBUFFER_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MPFB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define MPFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mpfb_pkg.sv @@
// Types, codes and constants of the page framebuffer engine.
package mpfb_pkg;

  localparam int DEF_WIDTH   = 128;
  localparam int DEF_HEIGHT  = 64;
  // wide enough for WIDTH*page+column and for any store address
  localparam int SUM_W       = 13;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 3;

  localparam logic [6:0] CLIP_RIGHT_RST  = 7'd127;
  localparam logic [5:0] CLIP_BOTTOM_RST = 6'd63;

  typedef enum logic [2:0] {
    REQ_PUT_PIXEL    = 3'd0,
    REQ_GET_PIXEL    = 3'd1,
    REQ_CLEAR_SCREEN = 3'd2,
    REQ_INVERT_RECT  = 3'd3,
    REQ_CLEAR_RECT   = 3'd4,
    REQ_IMAGE_BYTE   = 3'd5
  } req_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CLIP_ENABLE = 3'd0,
    CFG_CLIP_LEFT   = 3'd1,
    CFG_CLIP_TOP    = 3'd2,
    CFG_CLIP_RIGHT  = 3'd3,
    CFG_CLIP_BOTTOM = 3'd4,
    CFG_DRAW_COLOR  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] x_pos;
    logic [5:0] y_pos;
    logic [6:0] x_end;
    logic [5:0] y_end;
    logic [7:0] image_bits;
    logic [3:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic pixel_value;
    logic was_clipped;
  } out_item_t;

  typedef struct packed {
    logic       enable;
    logic [6:0] left;
    logic [5:0] top;
    logic [6:0] right;
    logic [5:0] bottom;
  } clip_cfg_t;

  // byte under work: page, column and the row span to touch in it
  typedef struct packed {
    logic [2:0] page;
    logic [7:0] col;
    logic [5:0] row_lo;
    logic [5:0] row_hi;
  } pos_t;

endpackage

@@ design/mono_page_framebuffer_engine.sv @@
// Single pixel requests: one byte is read and, for a put, written back; the result strobe follows.
// Rectangles: a read state and a write state per store byte touched, columns x..x_end times pages spanned.
// Image byte: a read state and a write state per drawn pixel; screen clear: one write per store byte.
// Empty rectangles, zero-length image runs and unused codes answer in the next cycle.
// Each byte passes through the shared pixel unit and the frame store in turn; busy falls as the result shows.
// Synchronous reset: a clearing pass zeroes the store, with busy high.
`include "mono_page_framebuffer_engine_macros.svh"

module mono_page_framebuffer_engine #(
  parameter int WIDTH  = mpfb_pkg::DEF_WIDTH,
  parameter int HEIGHT = mpfb_pkg::DEF_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mpfb_pkg::in_item_t                  req,
  output logic                                done,
  output mpfb_pkg::out_item_t                 result,
  input  logic                                wr_en,
  input  logic [mpfb_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [mpfb_pkg::CFG_DATA_W-1:0]     wr_data
);

  localparam int PAGES       = (HEIGHT + 7) / 8;
  localparam int STORE_BYTES = WIDTH * PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  mpfb_pkg::state_e    state, state_next;
  mpfb_pkg::req_e      kind;
  mpfb_pkg::req_e      req_kind;
  mpfb_pkg::clip_cfg_t clip;
  mpfb_pkg::pos_t      pos;
  mpfb_pkg::out_item_t result_next;

  logic                          draw_color;
  logic                          fill_on;
  logic [ADDR_W-1:0]             sweep;
  logic [2:0]                    page;
  logic [7:0]                    col;
  logic [5:0]                    row_lo;
  logic [5:0]                    row_hi;
  logic [6:0]                    x_first;
  logic [6:0]                    x_last;
  logic [2:0]                    page_last;
  logic [7:0]                    shift;
  logic [3:0]                    remain;
  logic [7:0]                    rdata;
  logic [7:0]                    mask;
  logic [mpfb_pkg::SUM_W-1:0]    addr_full;
  logic [ADDR_W-1:0]             unit_addr;
  logic [ADDR_W-1:0]             mem_addr;
  logic [7:0]                    mem_wdata;
  logic [7:0]                    new_byte;
  logic                          mem_we;
  logic                          accept;
  logic                          req_empty;
  logic                          sweep_last;
  logic                          last_byte;
  logic                          done_next;

  logic [7:0] store [STORE_BYTES];

  assign busy     = (state != mpfb_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign req_kind = mpfb_pkg::req_e'(req.req_type);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clip.enable <= 1'b0;
      clip.left   <= '0;
      clip.top    <= '0;
      clip.right  <= mpfb_pkg::CLIP_RIGHT_RST;
      clip.bottom <= mpfb_pkg::CLIP_BOTTOM_RST;
      draw_color  <= 1'b1;
    end else if (wr_en) begin
      unique case (mpfb_pkg::cfg_idx_e'(wr_index))
        mpfb_pkg::CFG_CLIP_ENABLE: clip.enable <= wr_data[0];
        mpfb_pkg::CFG_CLIP_LEFT:   clip.left   <= wr_data[6:0];
        mpfb_pkg::CFG_CLIP_TOP:    clip.top    <= wr_data[5:0];
        mpfb_pkg::CFG_CLIP_RIGHT:  clip.right  <= wr_data[6:0];
        mpfb_pkg::CFG_CLIP_BOTTOM: clip.bottom <= wr_data[5:0];
        mpfb_pkg::CFG_DRAW_COLOR:  draw_color  <= wr_data[0];
        default: ;
      endcase
    end
  end

  // requests that touch nothing
  always_comb begin
    unique case (req_kind)
      mpfb_pkg::REQ_PUT_PIXEL,
      mpfb_pkg::REQ_GET_PIXEL,
      mpfb_pkg::REQ_CLEAR_SCREEN: req_empty = 1'b0;
      mpfb_pkg::REQ_INVERT_RECT,
      mpfb_pkg::REQ_CLEAR_RECT:   req_empty = (req.x_end < req.x_pos) ||
                                              (req.y_end < req.y_pos);
      mpfb_pkg::REQ_IMAGE_BYTE:   req_empty = (req.bit_count == 4'd0);
      default:                    req_empty = 1'b1;
    endcase
  end

  // shared pixel unit
  assign pos = '{page: page, col: col, row_lo: row_lo, row_hi: row_hi};

  mpfb_pixel_unit #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_pixel (
    .clip (clip),
    .pos  (pos),
    .mask (mask),
    .addr (addr_full)
  );

  assign unit_addr = addr_full[ADDR_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mpfb_pkg::ST_CLEAR: if (sweep_last) state_next = mpfb_pkg::ST_IDLE;
      mpfb_pkg::ST_IDLE: begin
        if (accept && !req_empty) begin
          state_next = (req_kind == mpfb_pkg::REQ_CLEAR_SCREEN) ? mpfb_pkg::ST_FILL
                                                                : mpfb_pkg::ST_READ;
        end
      end
      mpfb_pkg::ST_FILL:  if (sweep_last) state_next = mpfb_pkg::ST_IDLE;
      mpfb_pkg::ST_READ:  state_next = mpfb_pkg::ST_WRITE;
      mpfb_pkg::ST_WRITE: state_next = last_byte ? mpfb_pkg::ST_IDLE : mpfb_pkg::ST_READ;
      default:            state_next = mpfb_pkg::ST_IDLE;
    endcase
  end

  // datapath controls and result
  always_comb begin
    sweep_last  = (sweep == ADDR_W'(STORE_BYTES - 1));
    last_byte   = 1'b1;
    new_byte    = rdata;
    mem_we      = 1'b0;
    mem_addr    = unit_addr;
    mem_wdata   = new_byte;
    done_next   = 1'b0;
    result_next = '0;

    case (kind)
      mpfb_pkg::REQ_PUT_PIXEL:   new_byte = draw_color ? (rdata | mask) : (rdata & ~mask);
      mpfb_pkg::REQ_INVERT_RECT: new_byte = rdata ^ mask;
      mpfb_pkg::REQ_CLEAR_RECT:  new_byte = rdata & ~mask;
      mpfb_pkg::REQ_IMAGE_BYTE:  new_byte = shift[7] ? (rdata & ~mask) : (rdata | mask);
      default:                   new_byte = rdata;
    endcase

    case (kind)
      mpfb_pkg::REQ_INVERT_RECT,
      mpfb_pkg::REQ_CLEAR_RECT: last_byte = (col[6:0] == x_last) && (page == page_last);
      mpfb_pkg::REQ_IMAGE_BYTE: last_byte = (remain == 4'd1);
      default:                  last_byte = 1'b1;
    endcase

    unique case (state)
      mpfb_pkg::ST_CLEAR,
      mpfb_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_addr  = sweep;
        mem_wdata = {8{fill_on}};
        done_next = (state == mpfb_pkg::ST_FILL) && sweep_last;
      end
      mpfb_pkg::ST_IDLE: begin
        done_next = accept && req_empty;
      end
      mpfb_pkg::ST_READ: ;
      mpfb_pkg::ST_WRITE: begin
        mem_we    = (mask != 8'd0) && (kind != mpfb_pkg::REQ_GET_PIXEL);
        mem_wdata = new_byte;
        done_next = last_byte;
        result_next.pixel_value = (kind == mpfb_pkg::REQ_GET_PIXEL) && ((rdata & mask) != 8'd0);
        result_next.was_clipped = ((kind == mpfb_pkg::REQ_GET_PIXEL) ||
                                   (kind == mpfb_pkg::REQ_PUT_PIXEL)) && (mask == 8'd0);
      end
      default: ;
    endcase
  end

  // frame store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) store[mem_addr] <= mem_wdata;
    rdata <= store[unit_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mpfb_pkg::ST_CLEAR;
      done    <= 1'b0;
      sweep   <= '0;
      fill_on <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if ((state == mpfb_pkg::ST_CLEAR) || (state == mpfb_pkg::ST_FILL)) begin
        sweep <= sweep_last ? '0 : sweep + ADDR_W'(1);
      end else if (accept) begin
        sweep   <= '0;
        fill_on <= draw_color;
      end
    end
  end

  // hold result for its one-cycle transfer
  always_ff @(posedge clk) begin
    if (done_next) result <= result_next;
  end

  // load the walk on a start transfer, advance it after each byte write
  always_ff @(posedge clk) begin
    if (accept) begin
      kind      <= req_kind;
      page      <= req.y_pos[5:3];
      col       <= {1'b0, req.x_pos};
      x_first   <= req.x_pos;
      x_last    <= req.x_end;
      page_last <= req.y_end[5:3];
      row_lo    <= req.y_pos;
      row_hi    <= ((req_kind == mpfb_pkg::REQ_INVERT_RECT) ||
                    (req_kind == mpfb_pkg::REQ_CLEAR_RECT)) ? req.y_end : req.y_pos;
      shift     <= req.image_bits;
      remain    <= (req.bit_count > 4'd8) ? 4'd8 : req.bit_count;
    end else if ((state == mpfb_pkg::ST_WRITE) && !last_byte) begin
      if (kind == mpfb_pkg::REQ_IMAGE_BYTE) begin
        col    <= col + 8'd1;
        shift  <= {shift[6:0], 1'b0};
        remain <= remain - 4'd1;
      end else if (col[6:0] == x_last) begin
        page <= page + 3'd1;
        col  <= {1'b0, x_first};
      end else begin
        col <= col + 8'd1;
      end
    end
  end

  `MPFB_ASSERT_NEXT(a_start_reacts, start && !busy, busy || done, "start transfer left no trace")
  `MPFB_ASSERT_IMPL(a_done_when_idle, done, !busy, "result strobe while busy")
  `MPFB_ASSERT_IMPL(a_clipped_reads_zero, done && result.was_clipped, !result.pixel_value,
                    "clipped pixel read as set")
  `MPFB_ASSERT_NEXT(a_read_then_write, state == mpfb_pkg::ST_READ,
                    state == mpfb_pkg::ST_WRITE, "byte read not followed by write")

endmodule

@@ design/mpfb_pixel_unit.sv @@
// Shared clip, bounds and address unit: bit mask and byte address of one store byte.
module mpfb_pixel_unit #(
  parameter int WIDTH  = mpfb_pkg::DEF_WIDTH,
  parameter int HEIGHT = mpfb_pkg::DEF_HEIGHT
) (
  input  mpfb_pkg::clip_cfg_t         clip,
  input  mpfb_pkg::pos_t              pos,
  output logic [7:0]                  mask,
  output logic [mpfb_pkg::SUM_W-1:0]  addr
);

  localparam int SUM_W = mpfb_pkg::SUM_W;

  logic col_ok;

  // column inside the screen and, when clipping, inside the window
  always_comb begin
    col_ok = ({1'b0, pos.col} < 9'(WIDTH)) &&
             (!clip.enable ||
              ((pos.col >= {1'b0, clip.left}) && (pos.col <= {1'b0, clip.right})));
  end

  // one compare set per bit of the page
  always_comb begin
    logic [5:0] row;
    logic       in_span;
    logic       on_screen;
    logic       in_clip;
    row = '0;
    for (int b = 0; b < 8; b++) begin
      row       = {pos.page, 3'(b)};
      in_span   = (row >= pos.row_lo) && (row <= pos.row_hi);
      on_screen = {3'b000, row} < 9'(HEIGHT);
      in_clip   = !clip.enable || ((row >= clip.top) && (row <= clip.bottom));
      mask[b]   = col_ok && in_span && on_screen && in_clip;
    end
  end

  // byte index WIDTH*page + column
  assign addr = SUM_W'(WIDTH) * SUM_W'(pos.page) + SUM_W'(pos.col);

endmodule
